FILE: design/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and character codes for the console line editor.
// ----------------------------------------------------------------------------
package cle_pkg;

    localparam logic [7:0] KEY_BS    = 8'h08;
    localparam logic [7:0] KEY_NL    = 8'h0A;
    localparam logic [7:0] KEY_SPACE = 8'h20;
    localparam logic [7:0] KEY_CARET = 8'h5E;
    localparam logic [7:0] CARET_OFS = 8'h40;

    localparam int         MAX_RES   = 3;

    typedef enum logic {
        ACT_KEY   = 1'b0,
        ACT_BEGIN = 1'b1
    } action_t;

    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_char;
        logic       store_valid;
        logic [7:0] store_index;
        logic [7:0] store_char;
        logic       line_done;
        logic [7:0] line_length;
        logic       last;
    } result_t;

    // Up to three results produced by one input transaction
    typedef struct packed {
        result_t [MAX_RES-1:0] res;
        logic    [1:0]         count;
    } step_t;

endpackage

FILE: design/cle_if.sv
// ----------------------------------------------------------------------------
// cle_if
// Valid/ready channels for key transactions and result transactions.
// ----------------------------------------------------------------------------
interface cle_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] key_byte;

    modport source (output valid, output action, output key_byte, input ready);
    modport sink   (input valid, input action, input key_byte, output ready);
endinterface

interface cle_out_if;
    logic       valid;
    logic       ready;
    logic       echo_valid;
    logic [7:0] echo_char;
    logic       store_valid;
    logic [7:0] store_index;
    logic [7:0] store_char;
    logic       line_done;
    logic [7:0] line_length;
    logic       last;

    modport source (
        output valid, output echo_valid, output echo_char, output store_valid,
        output store_index, output store_char, output line_done,
        output line_length, output last, input ready
    );
    modport sink (
        input valid, input echo_valid, input echo_char, input store_valid,
        input store_index, input store_char, input line_done,
        input line_length, input last, output ready
    );
endinterface

FILE: design/cle_step.sv
// ----------------------------------------------------------------------------
// cle_step
// Decodes one key or begin-line transaction against the current line state
// and produces its result set and the next line state.
// ----------------------------------------------------------------------------
module cle_step
    import cle_pkg::*;
#(
    parameter int LINE_DEPTH = 256
)
(
    input  logic       action,
    input  logic [7:0] key_byte,
    input  logic [7:0] char_count,
    input  logic       line_finished,
    input  logic [7:0] max_length,
    output step_t      step,
    output logic [7:0] char_count_next,
    output logic       line_finished_next
);

    localparam int         CAP_INT = (LINE_DEPTH - 1 < 255) ? LINE_DEPTH - 1 : 255;
    localparam logic [7:0] CAP     = CAP_INT[7:0];

    logic [7:0] limit;
    logic [7:0] grown;
    logic       room;

    // Keep the terminator inside the buffer
    assign limit = (max_length < CAP) ? max_length : CAP;
    assign room  = (char_count < limit);
    assign grown = room ? (char_count + 8'd1) : char_count;

    always_comb
    begin
        step               = '0;
        char_count_next    = char_count;
        line_finished_next = line_finished;

        if (action == ACT_BEGIN)
        begin
            char_count_next               = 8'd0;
            line_finished_next            = (limit == 8'd0);
            step.count                    = 2'd1;
            step.res[0].store_valid       = (limit == 8'd0);
            step.res[0].line_done         = (limit == 8'd0);
        end
        else if (line_finished)
        begin
            step.count = 2'd0;
        end
        else if (key_byte == KEY_BS)
        begin
            if (char_count != 8'd0)
            begin
                char_count_next           = char_count - 8'd1;
                step.count                = 2'd3;
                step.res[0].echo_valid    = 1'b1;
                step.res[0].echo_char     = KEY_BS;
                step.res[0].line_length   = char_count;
                step.res[1].echo_valid    = 1'b1;
                step.res[1].echo_char     = KEY_SPACE;
                step.res[1].line_length   = char_count;
                step.res[2].echo_valid    = 1'b1;
                step.res[2].echo_char     = KEY_BS;
                step.res[2].store_valid   = 1'b1;
                step.res[2].store_index   = char_count - 8'd1;
                step.res[2].line_length   = char_count - 8'd1;
            end
        end
        else if (key_byte == KEY_NL)
        begin
            line_finished_next        = 1'b1;
            step.count                = 2'd1;
            step.res[0].echo_valid    = 1'b1;
            step.res[0].echo_char     = KEY_NL;
            step.res[0].store_valid   = 1'b1;
            step.res[0].store_index   = char_count;
            step.res[0].line_done     = 1'b1;
            step.res[0].line_length   = char_count;
        end
        else if (key_byte < KEY_SPACE || key_byte[7])
        begin
            // Caret notation, nothing stored
            step.count                = 2'd2;
            step.res[0].echo_valid    = 1'b1;
            step.res[0].echo_char     = KEY_CARET;
            step.res[0].line_length   = char_count;
            step.res[1].echo_valid    = 1'b1;
            step.res[1].echo_char     = key_byte + CARET_OFS;
            step.res[1].line_length   = char_count;
        end
        else
        begin
            char_count_next           = grown;
            step.count                = 2'd1;
            step.res[0].echo_valid    = 1'b1;
            step.res[0].echo_char     = key_byte;
            step.res[0].store_valid   = room;
            step.res[0].store_index   = room ? char_count : 8'd0;
            step.res[0].store_char    = room ? key_byte : 8'd0;
            step.res[0].line_length   = grown;
            if (grown >= limit)
            begin
                line_finished_next        = 1'b1;
                step.count                = 2'd2;
                step.res[1].store_valid   = 1'b1;
                step.res[1].store_index   = grown;
                step.res[1].line_done     = 1'b1;
                step.res[1].line_length   = grown;
            end
        end

        case (step.count)
            2'd1:    step.res[0].last = 1'b1;
            2'd2:    step.res[1].last = 1'b1;
            2'd3:    step.res[2].last = 1'b1;
            default: ;
        endcase
    end

endmodule

FILE: design/console_line_editor.sv
// ----------------------------------------------------------------------------
// console_line_editor
// Canonical line editor: echoes keyboard bytes and reports line buffer writes.
// ----------------------------------------------------------------------------
// Each key or begin-line transaction yields zero to three result transactions
// (backspace on a non-empty line three, control bytes two, a printable byte
// that fills the line two, ignored keys none, others one). The line state
// updates when the key is taken, and its results sit in a three-entry result
// set that drains through one output register at one result per cycle while
// the output is not stalled; a new key is taken in the cycle the last result
// of the previous one moves to the output register. A key's first result
// passes from the result set to the output register. The user must write
// max_length only while no results are pending; the block does not enforce it.
module console_line_editor
    import cle_pkg::*;
#(
    parameter int LINE_DEPTH = 256
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          max_length_we,
    input  logic [7:0]    max_length_wdata,
    cle_in_if.sink        item,
    cle_out_if.source     result
);

    logic [7:0]               max_length_reg;
    logic [7:0]               char_count_reg;
    logic                     line_finished_reg;
    result_t [MAX_RES-1:0]    set_reg;
    logic [1:0]               pending_reg;
    logic [1:0]               ptr_reg;
    logic                     out_valid_reg;
    result_t                  out_data_reg;

    step_t                    step;
    logic [7:0]               char_count_next;
    logic                     line_finished_next;
    logic                     load;
    logic                     pop;
    logic                     take;

    cle_step #(.LINE_DEPTH(LINE_DEPTH)) u_step (
        .action             (item.action),
        .key_byte           (item.key_byte),
        .char_count         (char_count_reg),
        .line_finished      (line_finished_reg),
        .max_length         (max_length_reg),
        .step               (step),
        .char_count_next    (char_count_next),
        .line_finished_next (line_finished_next)
    );

    assign load       = !out_valid_reg || result.ready;
    assign pop        = load && (pending_reg != 2'd0);
    assign item.ready = (pending_reg == 2'd0) || (pending_reg == 2'd1 && pop);
    assign take       = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg    <= 8'hFF;
            char_count_reg    <= 8'd0;
            line_finished_reg <= 1'b0;
            pending_reg       <= 2'd0;
            ptr_reg           <= 2'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (max_length_we)
            begin
                max_length_reg <= max_length_wdata;
            end
            if (take)
            begin
                char_count_reg    <= char_count_next;
                line_finished_reg <= line_finished_next;
                pending_reg       <= step.count;
                ptr_reg           <= 2'd0;
            end
            else if (pop)
            begin
                pending_reg <= pending_reg - 2'd1;
                ptr_reg     <= ptr_reg + 2'd1;
            end
            if (load)
            begin
                out_valid_reg <= pop;
            end
        end
    end

    // Payload: no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            set_reg <= step.res;
        end
        if (pop)
        begin
            out_data_reg <= set_reg[ptr_reg];
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.echo_valid  = out_data_reg.echo_valid;
    assign result.echo_char   = out_data_reg.echo_char;
    assign result.store_valid = out_data_reg.store_valid;
    assign result.store_index = out_data_reg.store_index;
    assign result.store_char  = out_data_reg.store_char;
    assign result.line_done   = out_data_reg.line_done;
    assign result.line_length = out_data_reg.line_length;
    assign result.last        = out_data_reg.last;

endmodule

FILE: design/cle_checker.sv
// ----------------------------------------------------------------------------
// cle_checker
// Port-level checks on the result channel of the console line editor.
// ----------------------------------------------------------------------------
module cle_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       echo_valid,
    input logic [7:0] echo_char,
    input logic       store_valid,
    input logic [7:0] store_char,
    input logic       line_done,
    input logic       last
);

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A completing result ends its transaction and writes a terminator
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_done |-> last && store_valid && store_char == 8'd0)
        else $error("line completion without terminator or last");

    a_echo_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !echo_valid |-> echo_char == 8'd0)
        else $error("echo byte set without echo");

    // After a completion, a result that follows back to back must carry no echo (a begin-line)
    a_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && line_done ##1 out_valid |-> !echo_valid)
        else $error("key echoed after line completed");

endmodule

bind console_line_editor cle_checker u_cle_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .echo_valid  (result.echo_valid),
    .echo_char   (result.echo_char),
    .store_valid (result.store_valid),
    .store_char  (result.store_char),
    .line_done   (result.line_done),
    .last        (result.last)
);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the console line editor. Key and begin-line
// transactions go in with random gaps, the results drain under random
// back-pressure, and each result is checked field by field against a
// line-state predictor in the bench. Directed keys, limit edges, a full
// 255-character line and random multi-line phases are run in turn.
// ----------------------------------------------------------------------------
module tb_top;
    import cle_pkg::*;

    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         DRAIN_CYCLES = 20;
    localparam logic [7:0] HIGH_BYTE    = 8'h80;

    logic       clk              = 1'b0;
    logic       rst_n            = 1'b0;
    logic       max_length_we    = 1'b0;
    logic [7:0] max_length_wdata = 8'h00;

    cle_in_if  key_if();
    cle_out_if res_if();

    // Line state as the bench predicts it
    logic [7:0] line_limit;
    logic [7:0] line_count;
    bit         line_closed;
    result_t    expected_echoes[$];

    int error_count = 0;
    int cycle_count = 0;
    bit steady      = 1'b0;

    console_line_editor #(.LINE_DEPTH(256)) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .max_length_we    (max_length_we),
        .max_length_wdata (max_length_wdata),
        .item             (key_if),
        .result           (res_if)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("console_line_editor verification failed");
            $finish;
        end
    end

    function automatic result_t make_result(logic ev, logic [7:0] ec, logic sv,
                                            logic [7:0] si, logic [7:0] sc,
                                            logic done, logic [7:0] len);
        result_t r;
        r.echo_valid  = ev;
        r.echo_char   = ev ? ec : 8'h00;
        r.store_valid = sv;
        r.store_index = sv ? si : 8'h00;
        r.store_char  = sv ? sc : 8'h00;
        r.line_done   = done;
        r.line_length = len;
        r.last        = 1'b0;
        return r;
    endfunction

    // Update the line state for one accepted transaction and queue its results
    function automatic void edit_line(action_t act, logic [7:0] key);
        result_t r [MAX_RES];
        int      n;
        n = 0;
        if (act == ACT_BEGIN)
        begin
            line_count  = 8'h00;
            line_closed = 1'b0;
            if (line_limit == 8'h00)
            begin
                line_closed = 1'b1;
                r[0] = make_result(1'b0, 8'h00, 1'b1, 8'h00, 8'h00, 1'b1, 8'h00);
            end
            else
                r[0] = make_result(1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00);
            n = 1;
        end
        else if (line_closed)
            n = 0;
        else if (key == KEY_BS)
        begin
            if (line_count != 8'h00)
            begin
                r[0] = make_result(1'b1, KEY_BS, 1'b0, 8'h00, 8'h00, 1'b0, line_count);
                r[1] = make_result(1'b1, KEY_SPACE, 1'b0, 8'h00, 8'h00, 1'b0, line_count);
                line_count = line_count - 8'd1;
                r[2] = make_result(1'b1, KEY_BS, 1'b1, line_count, 8'h00, 1'b0, line_count);
                n = 3;
            end
        end
        else if (key == KEY_NL)
        begin
            line_closed = 1'b1;
            r[0] = make_result(1'b1, KEY_NL, 1'b1, line_count, 8'h00, 1'b1, line_count);
            n = 1;
        end
        else if (key < KEY_SPACE || key >= HIGH_BYTE)
        begin
            r[0] = make_result(1'b1, KEY_CARET, 1'b0, 8'h00, 8'h00, 1'b0, line_count);
            r[1] = make_result(1'b1, key + CARET_OFS, 1'b0, 8'h00, 8'h00, 1'b0,
                               line_count);
            n = 2;
        end
        else
        begin
            if (line_count < line_limit)
            begin
                r[0] = make_result(1'b1, key, 1'b1, line_count, key, 1'b0,
                                   line_count + 8'd1);
                line_count = line_count + 8'd1;
            end
            else
                r[0] = make_result(1'b1, key, 1'b0, 8'h00, 8'h00, 1'b0, line_count);
            n = 1;
            if (line_count >= line_limit)
            begin
                line_closed = 1'b1;
                r[1] = make_result(1'b0, 8'h00, 1'b1, line_count, 8'h00, 1'b1, line_count);
                n = 2;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1)
                r[i].last = 1'b1;
            expected_echoes.push_back(r[i]);
        end
    endfunction

    function automatic void check_result(result_t got);
        result_t want;
        if (expected_echoes.size() == 0)
        begin
            $error("unexpected result transaction: %h", got);
            error_count++;
            return;
        end
        want = expected_echoes.pop_front();
        if (got.echo_valid !== want.echo_valid)
        begin
            $error("echo_valid: expected %0h, actual %0h", want.echo_valid, got.echo_valid);
            error_count++;
        end
        if (got.echo_char !== want.echo_char)
        begin
            $error("echo_char: expected %0h, actual %0h", want.echo_char, got.echo_char);
            error_count++;
        end
        if (got.store_valid !== want.store_valid)
        begin
            $error("store_valid: expected %0h, actual %0h", want.store_valid,
                   got.store_valid);
            error_count++;
        end
        if (got.store_index !== want.store_index)
        begin
            $error("store_index: expected %0h, actual %0h", want.store_index,
                   got.store_index);
            error_count++;
        end
        if (got.store_char !== want.store_char)
        begin
            $error("store_char: expected %0h, actual %0h", want.store_char, got.store_char);
            error_count++;
        end
        if (got.line_done !== want.line_done)
        begin
            $error("line_done: expected %0h, actual %0h", want.line_done, got.line_done);
            error_count++;
        end
        if (got.line_length !== want.line_length)
        begin
            $error("line_length: expected %0h, actual %0h", want.line_length,
                   got.line_length);
            error_count++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0h, actual %0h", want.last, got.last);
            error_count++;
        end
    endfunction

    // Result side: random stall before each transaction, then check it
    initial
    begin : result_sink
        int      stall;
        result_t got;
        res_if.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!res_if.valid);
            got.echo_valid  = res_if.echo_valid;
            got.echo_char   = res_if.echo_char;
            got.store_valid = res_if.store_valid;
            got.store_index = res_if.store_index;
            got.store_char  = res_if.store_char;
            got.line_done   = res_if.line_done;
            got.line_length = res_if.line_length;
            got.last        = res_if.last;
            check_result(got);
        end
    end

    task automatic send_key(action_t act, logic [7:0] key);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            key_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        key_if.valid    <= 1'b1;
        key_if.action   <= act;
        key_if.key_byte <= key;
        do @(posedge clk); while (!key_if.ready);
        edit_line(act, key);
    endtask

    // Hold the sender until every result is in, then let the block settle
    task automatic wait_idle();
        key_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_echoes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_max_length(logic [7:0] value);
        wait_idle();
        max_length_we    <= 1'b1;
        max_length_wdata <= value;
        @(posedge clk);
        max_length_we    <= 1'b0;
        line_limit = value;
    endtask

    function automatic logic [7:0] pick_key();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 8'($urandom_range(32'h20, 32'h7F));
        else if (pick < 72)
            return KEY_BS;
        else if (pick < 78)
            return KEY_NL;
        else if (pick < 90)
            return 8'($urandom_range(0, 31));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // Every key class at the reset limit, including ignored keys
    task automatic test_basic_keys();
        send_key(ACT_BEGIN, 8'hFF);
        send_key(ACT_KEY, KEY_BS);          // empty line: no result
        send_key(ACT_KEY, 8'h41);
        send_key(ACT_KEY, KEY_SPACE);
        send_key(ACT_KEY, 8'h7E);
        send_key(ACT_KEY, 8'h7F);
        send_key(ACT_KEY, 8'h00);
        send_key(ACT_KEY, 8'h1F);
        send_key(ACT_KEY, HIGH_BYTE);
        send_key(ACT_KEY, 8'hFF);
        send_key(ACT_KEY, KEY_BS);
        send_key(ACT_KEY, KEY_BS);
        send_key(ACT_KEY, KEY_NL);
        send_key(ACT_KEY, 8'h5A);           // line done: ignored
        send_key(ACT_KEY, KEY_BS);
        send_key(ACT_BEGIN, 8'h00);
        send_key(ACT_KEY, KEY_NL);          // newline on an empty line
    endtask

    task automatic test_limit_edges();
        set_max_length(8'd0);
        send_key(ACT_BEGIN, 8'h55);
        send_key(ACT_KEY, 8'h71);
        set_max_length(8'd1);
        send_key(ACT_BEGIN, 8'hAA);
        send_key(ACT_KEY, 8'h78);
        set_max_length(8'd3);
        send_key(ACT_BEGIN, 8'h00);
        send_key(ACT_KEY, 8'h61);
        send_key(ACT_KEY, 8'h62);
        // lower the limit under the current count
        set_max_length(8'd1);
        send_key(ACT_KEY, 8'h63);
    endtask

    // Fill one line to the widest limit, mostly printable keys
    task automatic test_full_line();
        int         pick;
        logic [7:0] key;
        set_max_length(8'd255);
        steady = 1'b1;
        send_key(ACT_BEGIN, 8'($urandom_range(0, 255)));
        for (int i = 0; i < 400 && !line_closed; i++)
        begin
            if (i == 60)
                steady = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 92)
                key = 8'($urandom_range(32'h20, 32'h7F));
            else if (pick < 95)
                key = KEY_BS;
            else
                key = 8'($urandom_range(0, 31)) | (8'($urandom_range(0, 1)) << 7);
            if (key == KEY_NL)
                key = 8'h0B;
            send_key(ACT_KEY, key);
        end
    endtask

    task automatic test_random_lines();
        action_t    act;
        logic [7:0] key;
        bit         fires;
        int         counted;
        int         quota;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       set_max_length(8'($urandom_range(1, 6)));
                1:       set_max_length(8'd0);
                2:       set_max_length(8'($urandom_range(7, 40)));
                3:       set_max_length(8'd255);
                4:       set_max_length(8'($urandom_range(1, 3)));
                default: set_max_length(8'($urandom_range(0, 255)));
            endcase
            steady  = (phase == 4);
            quota   = (phase == 1) ? 4 : 9;
            counted = 0;
            while (counted < quota)
            begin
                if (line_closed ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 11) == 0))
                begin
                    act = ACT_BEGIN;
                    key = 8'($urandom_range(0, 255));
                end
                else
                begin
                    act = ACT_KEY;
                    key = pick_key();
                end
                fires = (act == ACT_BEGIN) ||
                        (!line_closed && !(key == KEY_BS && line_count == 8'h00));
                send_key(act, key);
                if (fires)
                    counted++;
            end
        end
    endtask

    initial
    begin
        key_if.valid    <= 1'b0;
        key_if.action   <= ACT_KEY;
        key_if.key_byte <= 8'h00;
        line_limit  = 8'd255;
        line_count  = 8'h00;
        line_closed = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_keys();
        test_limit_edges();
        test_full_line();
        test_random_lines();
        wait_idle();
        if (error_count == 0)
            $display("console_line_editor verification clean");
        else
            $display("console_line_editor verification failed");
        $finish;
    end

endmodule
